### rtl/hlnorm_pkg.sv
// Shared types, constants and helpers for the header line normalizer.
package hlnorm_pkg;

    localparam int HOLD_DEPTH  = 32;
    localparam int MAX_RESULTS = 36;
    localparam int PTR_W       = $clog2(HOLD_DEPTH);
    localparam int CNT_W       = $clog2(HOLD_DEPTH + 1);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ADDR  = 2'd1;
    localparam logic [1:0] MODE_NEWS  = 2'd2;

    localparam logic [1:0] PH_SKIP_LEAD  = 2'd0;
    localparam logic [1:0] PH_NORMAL     = 2'd1;
    localparam logic [1:0] PH_SKIP_COMMA = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
        logic       was_empty;
        logic       hold_overflow;
    } out_beat_t;

    typedef enum logic {
        SRC_INPUT,
        SRC_RDATA
    } emit_src_t;

    typedef enum logic [1:0] {
        HS_INPUT,
        HS_CR,
        HS_LF,
        HS_TAB
    } hold_sel_t;

    typedef struct packed {
        logic       load_in;
        logic       emit;
        emit_src_t  emit_src;
        logic       pop;
        logic       set_ovf;
        logic       hold_wr;
        hold_sel_t  hold_sel;
        logic       pcr_we;
        logic       pcr_val;
        logic       phase_upd;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] phase;
        logic       pcr;
        logic       is_ws;
        logic       is_cr;
        logic       is_lf;
        logic       cnt_zero;
        logic       cnt_one;
        logic       cnt_full;
        logic       out_free;
    } status_t;

    function automatic logic is_ws(input logic [7:0] b);
        return ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_SPACE);
    endfunction

endpackage

### rtl/hlnorm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hlnorm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/hlnorm_ctrl.sv
// Sequencing state machine of the header line normalizer.
module hlnorm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hlnorm_pkg::status_t status,
    output hlnorm_pkg::cmd_t    cmd
);
    import hlnorm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_HOLD_CHK,
        ST_OVF_RD,
        ST_OVF_EM,
        ST_HOLD_WR,
        ST_FL_RD,
        ST_FL_EM,
        ST_EMIT_B,
        ST_FINISH
    } state_t;

    localparam logic [1:0] HIDX_LAST = 2'd2;

    state_t     state_reg, state_next;
    logic [1:0] hidx_reg, hidx_next;
    logic       multi_reg, multi_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        hidx_next  = hidx_reg;
        multi_next = multi_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (status.mode == MODE_ADDR) begin
                    state_next = ST_EMIT_B;
                end else if (status.phase != PH_NORMAL) begin
                    cmd.pcr_we = 1'b1;
                    if (status.is_ws) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = status.cnt_zero ? ST_EMIT_B : ST_FL_RD;
                    end
                end else if (status.is_cr || status.is_lf) begin
                    cmd.pcr_we = 1'b1;
                    if (status.is_lf && status.pcr) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.pcr_val = status.is_cr;
                        multi_next  = 1'b1;
                        hidx_next   = 2'd0;
                        state_next  = ST_HOLD_CHK;
                    end
                end else if (status.is_ws) begin
                    cmd.pcr_we = 1'b1;
                    multi_next = 1'b0;
                    hidx_next  = 2'd0;
                    state_next = ST_HOLD_CHK;
                end else begin
                    cmd.pcr_we = 1'b1;
                    state_next = status.cnt_zero ? ST_EMIT_B : ST_FL_RD;
                end
            end
            ST_HOLD_CHK: begin
                state_next = status.cnt_full ? ST_OVF_RD : ST_HOLD_WR;
            end
            ST_OVF_RD: begin
                state_next = ST_OVF_EM;
            end
            ST_OVF_EM: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_RDATA;
                    cmd.pop      = 1'b1;
                    cmd.set_ovf  = 1'b1;
                    state_next   = ST_HOLD_WR;
                end
            end
            ST_HOLD_WR: begin
                cmd.hold_wr = 1'b1;
                if (!multi_reg) begin
                    cmd.hold_sel = HS_INPUT;
                end else begin
                    case (hidx_reg)
                        2'd0:    cmd.hold_sel = HS_CR;
                        2'd1:    cmd.hold_sel = HS_LF;
                        default: cmd.hold_sel = HS_TAB;
                    endcase
                end
                if (multi_reg && (hidx_reg != HIDX_LAST)) begin
                    hidx_next  = hidx_reg + 2'd1;
                    state_next = ST_HOLD_CHK;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FL_RD: begin
                state_next = ST_FL_EM;
            end
            ST_FL_EM: begin
                if (status.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = SRC_RDATA;
                    cmd.pop      = 1'b1;
                    state_next   = status.cnt_one ? ST_EMIT_B : ST_FL_RD;
                end
            end
            ST_EMIT_B: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = SRC_INPUT;
                    cmd.phase_upd = (status.mode != MODE_ADDR);
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hidx_reg  <= 2'd0;
            multi_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            hidx_reg  <= hidx_next;
            multi_reg <= multi_next;
        end
    end

endmodule

### rtl/hlnorm_dp.sv
// Datapath of the header line normalizer: hold store, pending result and output register.
module hlnorm_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    input  hlnorm_pkg::in_beat_t  s_data,
    input  hlnorm_pkg::cmd_t      cmd,
    output hlnorm_pkg::status_t   status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hlnorm_pkg::out_beat_t m_data
);
    import hlnorm_pkg::*;

    logic [1:0]       mode_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic [1:0]       phase_reg, phase_next;
    logic             pcr_reg, pcr_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             emitted_reg, emitted_next;
    logic             ovf_reg, ovf_next;
    logic             pend_valid_reg, pend_valid_next;
    out_beat_t        pend_reg, pend_next;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_reg, out_next;

    logic [7:0] rd_data;
    logic [7:0] hold_data;
    logic [7:0] emit_byte;
    logic       keep;
    logic       push;
    logic       end_hdr;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(HOLD_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    hlnorm_ram #(
        .WIDTH (8),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .aclk    (aclk),
        .wr_en   (cmd.hold_wr),
        .wr_addr (tail_reg),
        .wr_data (hold_data),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        case (cmd.hold_sel)
            HS_CR:   hold_data = CH_CR;
            HS_LF:   hold_data = CH_LF;
            HS_TAB:  hold_data = CH_TAB;
            default: hold_data = byte_reg;
        endcase
    end

    assign emit_byte = (cmd.emit_src == SRC_RDATA) ? rd_data : byte_reg;
    assign keep      = (rcnt_reg < RCNT_W'(MAX_RESULTS));
    assign end_hdr   = cmd.finish && last_reg;

    assign status.mode     = mode_reg;
    assign status.phase    = phase_reg;
    assign status.pcr      = pcr_reg;
    assign status.is_ws    = is_ws(byte_reg);
    assign status.is_cr    = (byte_reg == CH_CR);
    assign status.is_lf    = (byte_reg == CH_LF);
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.cnt_one  = (cnt_reg == CNT_W'(1));
    assign status.cnt_full = (cnt_reg == CNT_W'(HOLD_DEPTH));
    assign status.out_free = !out_valid_reg || m_ready;

    always_comb begin
        phase_next      = phase_reg;
        pcr_next        = pcr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        emitted_next    = emitted_reg;
        ovf_next        = ovf_reg | cmd.set_ovf;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rcnt_next       = rcnt_reg;
        out_next        = out_reg;
        push            = 1'b0;

        if (cmd.pcr_we) begin
            pcr_next = cmd.pcr_val;
        end
        if (cmd.phase_upd) begin
            phase_next = ((mode_reg == MODE_NEWS) && (byte_reg == CH_COMMA)) ?
                         PH_SKIP_COMMA : PH_NORMAL;
        end
        if (cmd.pop) begin
            head_next = ptr_inc(head_reg);
            cnt_next  = cnt_reg - CNT_W'(1);
        end
        if (cmd.hold_wr) begin
            tail_next = ptr_inc(tail_reg);
            cnt_next  = cnt_reg + CNT_W'(1);
        end

        // A result is parked one deep so that the step's final one can be marked.
        if (cmd.emit) begin
            emitted_next = 1'b1;
            if (keep) begin
                push                    = pend_valid_reg;
                out_next                = pend_reg;
                pend_valid_next         = 1'b1;
                pend_next.out_byte      = emit_byte;
                pend_next.has_byte      = 1'b1;
                pend_next.out_last      = 1'b0;
                pend_next.was_empty     = 1'b0;
                pend_next.hold_overflow = ovf_reg | cmd.set_ovf;
                rcnt_next               = rcnt_reg + RCNT_W'(1);
            end
        end

        if (cmd.finish) begin
            push = pend_valid_reg || last_reg;
            if (pend_valid_reg) begin
                out_next = pend_reg;
            end else begin
                out_next.out_byte = 8'h00;
                out_next.has_byte = 1'b0;
            end
            out_next.out_last  = last_reg;
            out_next.was_empty = last_reg && !emitted_reg;
            if (last_reg || !pend_valid_reg) begin
                out_next.hold_overflow = ovf_reg;
            end
            pend_valid_next = 1'b0;
            rcnt_next       = '0;
        end

        if (end_hdr) begin
            phase_next   = PH_SKIP_LEAD;
            pcr_next     = 1'b0;
            head_next    = '0;
            tail_next    = '0;
            cnt_next     = '0;
            emitted_next = 1'b0;
        end

        if (push) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_PLAIN;
            phase_reg      <= PH_SKIP_LEAD;
            pcr_reg        <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            emitted_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            rcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            pcr_reg        <= pcr_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
            emitted_reg    <= emitted_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            rcnt_reg       <= rcnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            byte_reg <= s_data.in_byte;
            last_reg <= s_data.in_last;
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/header_line_normalizer.sv
// Top level of the header line normalizer: controller, datapath and checks.
//
// The block takes a mail header one byte per input beat on the s_ channel
// (in_last marks the final byte) and returns normalised bytes on the m_
// channel. In address mode every byte passes unchanged. In the other modes
// leading whitespace is dropped, as is whitespace after a comma in news mode,
// each line break becomes CR LF TAB, and whitespace runs are held back in a
// 32-entry hold RAM until a non-space byte follows, so trailing whitespace
// appears only when a full hold RAM pushes its oldest byte out early. The
// header mode is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce.
// One byte is handled at a time. A held run is flushed by reading each entry
// from the hold RAM through its registered read port. The final beat of a
// step appears on m_ in the cycle after the step closes; earlier beats leave
// as the next one is emitted. The last beat of a step waits in a one-deep
// park register so that the end-of-header beat can be marked. Synchronous
// reset clears the mode to plain header, empties the hold RAM count and the
// overflow flag; no clearing pass is needed. When the receiver stalls, the
// output register holds its beat and the controller waits, so no beat is
// lost.
module header_line_normalizer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hlnorm_pkg::in_beat_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hlnorm_pkg::out_beat_t m_data
);
    import hlnorm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller steps through decode, hold, flush and finish phases.
    hlnorm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath owns every piece of header state and the output register.
    hlnorm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // The hold RAM is never written when full, nor read out when empty.
    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hold_wr |-> !status.cnt_full)
        else $error("hold RAM written while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !status.cnt_zero)
        else $error("hold RAM popped while empty");

    // A beat is only moved into the output register when it is free.
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit || cmd.finish) |-> status.out_free)
        else $error("output register overwritten while stalled");

    // An empty header ends with a bare terminator.
    a_empty_bare: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_last && m_data.was_empty) |-> !m_data.has_byte)
        else $error("empty header flagged on a data beat");

endmodule
